// ===== sv/vce_pkg.sv =====
// Shared constants and helpers for the vehicle curvature estimator.
`timescale 1ns / 1ps
package vce_pkg;

  localparam int unsigned CURVATURE_FRAC_BITS = 24;

  localparam logic [63:0] CF_C0 = 64'd1778682516;
  localparam logic [63:0] CF_C1 = 64'd736608984;
  localparam logic [63:0] CF_CX = 64'd31668292;
  localparam logic [63:0] QF_A0 = 64'd3412395;
  localparam logic [63:0] QF_A1 = 64'd2711;
  localparam logic [63:0] QF_AY = 64'd70145287;
  localparam logic [25:0] TWO_PI_E7 = 26'd62831853;

  localparam logic [14:0] MIN_SPEED_RST = 15'd100;
  localparam logic [24:0] STRAIGHT_RST = 25'd6711;
  localparam logic [24:0] MAX_CURV_RST = 25'd16777216;

  localparam logic [3:0] REG_MIN_SPEED = 4'd0;
  localparam logic [3:0] REG_STRAIGHT = 4'd4;
  localparam logic [3:0] REG_MAX_CURV = 4'd8;

  // sign and magnitude to two's complement, saturated to w bits
  function automatic logic [63:0] sat_mag(input logic neg, input logic [63:0] mag,
                                          input int unsigned w);
    logic [63:0] lim;
    lim = (64'd1 << (w - 1)) - 64'd1;
    if (neg) begin
      if (mag > lim + 64'd1) return ~lim;
      return (~mag) + 64'd1;
    end
    if (mag > lim) return lim;
    return mag;
  endfunction

  function automatic logic [3:0] conf_of(input logic [31:0] ag);
    if (ag == 32'd0) return 4'd10;
    if (ag <= 32'd571) return 4'd9;
    if (ag <= 32'd1143) return 4'd8;
    if (ag <= 32'd1715) return 4'd7;
    if (ag <= 32'd2287) return 4'd6;
    if (ag <= 32'd2859) return 4'd5;
    if (ag <= 32'd5719) return 4'd4;
    if (ag <= 32'd11438) return 4'd3;
    if (ag <= 32'd17157) return 4'd2;
    if (ag <= 32'd22876) return 4'd1;
    return 4'd0;
  endfunction

endpackage

// ===== sv/vehicle_curvature_estimator.sv =====
// Vehicle curvature estimator: bit-serial divider and multiply-accumulate sequencer.
// A division takes a rounding step, then one quotient bit per cycle; a filter tap takes a
//   setup step, then steps through the multiplier bits.
// One transaction at a time; the next is taken the cycle after the result is
//   registered, later while the result waits for m_axis_tready.
// Zero delta after the first sample: accepted without result. Sync reset restores defaults.
`timescale 1ns / 1ps
module vehicle_curvature_estimator #(
  parameter int unsigned CURVATURE_FRAC_BITS = vce_pkg::CURVATURE_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // speed[15:0], heading[31:16], yaw_in[52:32], acceleration[68:53], delta_ms[84:69]
  input  logic [87:0] s_axis_tdata,
  // yaw_valid[0], acceleration_valid[1]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // curvature[25:0], confidence[29:26], yaw_used[50:30], acceleration_used[66:51]
  output logic [71:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_ACC    = 5'd1;
  localparam logic [4:0] ST_ACC_W  = 5'd2;
  localparam logic [4:0] ST_YAW    = 5'd3;
  localparam logic [4:0] ST_YAW_W  = 5'd4;
  localparam logic [4:0] ST_CURV   = 5'd5;
  localparam logic [4:0] ST_CURV_W = 5'd6;
  localparam logic [4:0] ST_CF1    = 5'd7;
  localparam logic [4:0] ST_CF2    = 5'd8;
  localparam logic [4:0] ST_CRND   = 5'd9;
  localparam logic [4:0] ST_Q0     = 5'd10;
  localparam logic [4:0] ST_Q1     = 5'd11;
  localparam logic [4:0] ST_Q2     = 5'd12;
  localparam logic [4:0] ST_QRND   = 5'd13;
  localparam logic [4:0] ST_DIVR   = 5'd14;
  localparam logic [4:0] ST_DIV    = 5'd15;
  localparam logic [4:0] ST_MAC    = 5'd16;
  localparam logic [4:0] ST_OUT    = 5'd17;

  localparam logic [42:0] TWO_PI_E7_EXT = 43'(vce_pkg::TWO_PI_E7);

  logic [4:0] state, ret;

  logic [14:0] min_speed;
  logic [24:0] straight_threshold, max_curvature;

  logic               started;
  logic [15:0]        last_heading;
  logic signed [15:0] last_speed;
  logic signed [31:0] h0, h1, g0, g1;
  logic [1:0]         fill;
  logic signed [20:0] last_yaw;

  logic signed [15:0] speed, acc_in;
  logic [15:0]        heading, delta;
  logic signed [20:0] yaw_in;
  logic               yaw_ok, acc_ok;

  logic signed [20:0] yaw_used;
  logic signed [15:0] acc_used;
  logic signed [31:0] raw;
  logic signed [25:0] curv;
  logic [3:0]         conf;

  // divider
  logic [63:0] dvd;
  logic [31:0] rem;
  logic [31:0] den;
  logic        dneg;
  logic [6:0]  dcnt;
  // multiply-accumulate
  logic [63:0]        mc;
  logic [31:0]        mp;
  logic               mneg;
  logic [5:0]         mcnt;
  logic signed [65:0] acc;

  logic [71:0] out_data;
  logic        out_valid;

  // combinational helpers
  logic [16:0]        speed_mag;
  logic               speed_ok;
  logic signed [16:0] sdiff;
  logic [16:0]        sdiff_mag;
  logic [15:0]        hdiff;
  logic               hneg;
  logic [16:0]        hmag;
  logic [32:0]        rem_sh;
  logic [65:0]        acc_mag;
  logic [35:0]        rnd;
  logic signed [31:0] rnd_s;
  logic [31:0]        rnd_abs;
  logic signed [21:0] dyaw;
  logic [63:0]        qsel;

  assign speed_mag = speed[15] ? 17'(-$signed({speed[15], speed})) : {1'b0, speed};
  assign speed_ok  = (speed_mag >= {2'b0, min_speed}) && (speed != 16'sd0);
  assign sdiff     = 17'(speed) - 17'(last_speed);
  assign sdiff_mag = sdiff[16] ? 17'(-sdiff) : 17'(sdiff);
  assign hdiff     = last_heading - heading;
  assign hneg      = hdiff > 16'd32768;
  assign hmag      = hneg ? 17'(17'd65536 - {1'b0, hdiff}) : {1'b0, hdiff};
  assign rem_sh    = {rem, dvd[63]};
  assign acc_mag   = acc[65] ? 66'(-acc) : 66'(acc);
  assign rnd       = 36'((acc_mag + 66'd536870912) >> 30);
  assign rnd_s     = 32'(vce_pkg::sat_mag(acc[65], {28'd0, rnd}, 32));
  assign rnd_abs   = rnd_s[31] ? 32'(-rnd_s) : 32'(rnd_s);
  assign dyaw      = 22'(yaw_used) - 22'(last_yaw);
  assign qsel      = dvd;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign pready        = 1'b1;

  always_comb begin
    unique case (paddr)
      vce_pkg::REG_MIN_SPEED: prdata = {17'd0, min_speed};
      vce_pkg::REG_STRAIGHT:  prdata = {7'd0, straight_threshold};
      vce_pkg::REG_MAX_CURV:  prdata = {7'd0, max_curvature};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_speed          <= vce_pkg::MIN_SPEED_RST;
      straight_threshold <= vce_pkg::STRAIGHT_RST;
      max_curvature      <= vce_pkg::MAX_CURV_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr == vce_pkg::REG_MIN_SPEED) min_speed <= pwdata[14:0];
      if (paddr == vce_pkg::REG_STRAIGHT) straight_threshold <= pwdata[24:0];
      if (paddr == vce_pkg::REG_MAX_CURV) max_curvature <= pwdata[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ret          <= ST_IDLE;
      started      <= 1'b0;
      last_heading <= '0;
      last_speed   <= '0;
      h0           <= '0;
      h1           <= '0;
      g0           <= '0;
      g1           <= '0;
      fill         <= '0;
      last_yaw     <= '0;
      out_valid    <= 1'b0;
      dcnt         <= '0;
      mcnt         <= '0;
    end else begin
      if (out_valid && m_axis_tready && state != ST_OUT) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            speed   <= s_axis_tdata[15:0];
            heading <= s_axis_tdata[31:16];
            yaw_in  <= s_axis_tdata[52:32];
            acc_in  <= s_axis_tdata[68:53];
            delta   <= s_axis_tdata[84:69];
            yaw_ok  <= s_axis_tuser[0];
            acc_ok  <= s_axis_tuser[1];
            curv    <= '0;
            if (!(started && s_axis_tdata[84:69] == 16'd0)) state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (started && !acc_ok) begin
            dvd   <= {37'd0, {10'd0, sdiff_mag} * 27'd1000};
            dneg  <= sdiff[16];
            den   <= {16'd0, delta};
            ret   <= ST_ACC_W;
            state <= ST_DIVR;
          end else begin
            acc_used <= acc_ok ? acc_in : 16'sd0;
            state    <= ST_YAW;
          end
        end
        ST_ACC_W: begin
          acc_used <= 16'(vce_pkg::sat_mag(dneg, qsel, 16));
          state    <= ST_YAW;
        end
        ST_YAW: begin
          if (started && !yaw_ok) begin
            dvd   <= {21'd0, 43'(hmag * TWO_PI_E7_EXT)};
            dneg  <= hneg;
            den   <= {delta, 16'd0};
            ret   <= ST_YAW_W;
            state <= ST_DIVR;
          end else begin
            yaw_used <= yaw_ok ? yaw_in : 21'sd0;
            state    <= ST_CURV;
          end
        end
        ST_YAW_W: begin
          yaw_used <= 21'(vce_pkg::sat_mag(dneg, qsel, 21));
          state    <= ST_CURV;
        end
        ST_CURV: begin
          started      <= 1'b1;
          last_heading <= heading;
          last_speed   <= speed;
          if (speed_ok) begin
            dvd   <= {43'd0, (yaw_used[20] ? 21'(-yaw_used) : 21'(yaw_used))}
                     << CURVATURE_FRAC_BITS;
            dneg  <= yaw_used[20] ^ speed[15];
            den   <= {15'd0, speed_mag} * 32'd100;
            ret   <= ST_CURV_W;
            state <= ST_DIVR;
          end else begin
            state <= ST_Q0;
          end
        end
        ST_CURV_W: begin
          if (fill < 2'd2) begin
            h1    <= h0;
            h0    <= 32'(vce_pkg::sat_mag(dneg, qsel, 32));
            fill  <= fill + 2'd1;
            state <= ST_Q0;
          end else begin
            raw   <= 32'(vce_pkg::sat_mag(dneg, qsel, 32));
            acc   <= '0;
            mc    <= vce_pkg::CF_C0;
            mp    <= h0[31] ? 32'(-h0) : 32'(h0);
            mneg  <= h0[31];
            mcnt  <= 6'd32;
            ret   <= ST_CF1;
            state <= ST_MAC;
          end
        end
        ST_CF1: begin
          mc    <= vce_pkg::CF_C1;
          mp    <= h1[31] ? 32'(-h1) : 32'(h1);
          mneg  <= ~h1[31];
          mcnt  <= 6'd32;
          ret   <= ST_CF2;
          state <= ST_MAC;
        end
        ST_CF2: begin
          mc    <= vce_pkg::CF_CX;
          mp    <= raw[31] ? 32'(-raw) : 32'(raw);
          mneg  <= raw[31];
          mcnt  <= 6'd32;
          ret   <= ST_CRND;
          state <= ST_MAC;
        end
        ST_CRND: begin
          h1 <= h0;
          h0 <= rnd_s;
          if (rnd_abs < {7'd0, straight_threshold}) curv <= '0;
          else if (rnd_abs > {7'd0, max_curvature})
            curv <= rnd_s[31] ? 26'(-{1'b0, max_curvature}) : {1'b0, max_curvature};
          else curv <= 26'(rnd_s);
          state <= ST_Q0;
        end
        ST_Q0: begin
          acc   <= '0;
          mc    <= vce_pkg::QF_A0;
          mp    <= g0[31] ? 32'(-g0) : 32'(g0);
          mneg  <= g0[31];
          mcnt  <= 6'd32;
          ret   <= ST_Q1;
          state <= ST_MAC;
        end
        ST_Q1: begin
          mc    <= vce_pkg::QF_A1;
          mp    <= g1[31] ? 32'(-g1) : 32'(g1);
          mneg  <= ~g1[31];
          mcnt  <= 6'd32;
          ret   <= ST_Q2;
          state <= ST_MAC;
        end
        ST_Q2: begin
          mc    <= vce_pkg::QF_AY;
          mp    <= dyaw[21] ? 32'(-dyaw) : 32'(dyaw);
          mneg  <= dyaw[21];
          mcnt  <= 6'd32;
          ret   <= ST_QRND;
          state <= ST_MAC;
        end
        ST_QRND: begin
          g1       <= g0;
          g0       <= rnd_s;
          last_yaw <= yaw_used;
          conf     <= vce_pkg::conf_of(rnd_abs);
          state    <= ST_OUT;
        end
        ST_DIVR: begin
          dvd   <= dvd + {33'd0, den[31:1]};
          rem   <= '0;
          dcnt  <= 7'd64;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (rem_sh >= {1'b0, den}) begin
            rem <= 32'(rem_sh - {1'b0, den});
            dvd <= {dvd[62:0], 1'b1};
          end else begin
            rem <= rem_sh[31:0];
            dvd <= {dvd[62:0], 1'b0};
          end
          dcnt <= dcnt - 7'd1;
          if (dcnt == 7'd1) state <= ret;
        end
        ST_MAC: begin
          if (mp[0]) acc <= mneg ? acc - 66'(mc) : acc + 66'(mc);
          mc   <= mc << 1;
          mp   <= mp >> 1;
          mcnt <= mcnt - 6'd1;
          if (mcnt == 6'd1) state <= ret;
        end
        ST_OUT: begin
          if (!out_valid || m_axis_tready) begin
            out_data[25:0]  <= curv;
            out_data[29:26] <= conf;
            out_data[50:30] <= yaw_used;
            out_data[66:51] <= acc_used;
            out_data[71:67] <= '0;
            out_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("curvature history fill count out of range");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!out_valid || m_axis_tready)) |=> (out_valid && state == ST_IDLE))
    else $error("result not registered on completion");
  a_conf_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data[29:26] <= 4'd10))
    else $error("confidence out of range");
  a_started_sticky: assert property (@(posedge clk) disable iff (rst) !$fell(started))
    else $error("started flag cleared outside reset");

endmodule
